[design/ntdc_pkg.sv]
// ---------------------------------------------------------------------------
// ntdc_pkg
// Shared constants and types for the decimal display writer.
// ---------------------------------------------------------------------------
package ntdc_pkg;

  localparam int DISPLAY_CHARS = 16;
  localparam int POS_IDX_W     = $clog2(DISPLAY_CHARS);
  localparam int POS_CNT_W     = $clog2(DISPLAY_CHARS + 1);

  localparam int VALUE_W       = 32;
  localparam int DIGITS        = 10;
  localparam int BCD_W         = 4 * DIGITS;
  localparam int DIGIT_CNT_W   = $clog2(DIGITS + 1);
  localparam int BIT_CNT_W     = $clog2(VALUE_W);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // converter status toward the scanner
  typedef struct packed {
    logic       ready;   // digits stripped of leading zeros, available
    logic       avail;   // at least one digit left to take
    logic [3:0] digit;   // most significant remaining digit
  } cvt_status_t;

endpackage

[design/ntdc_item_if.sv]
// ---------------------------------------------------------------------------
// ntdc_item_if
// Input channel: one number to show and where to put it.
// ---------------------------------------------------------------------------
interface ntdc_item_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] value;
  logic [3:0]  start_position;

  modport source (output valid, kind, value, start_position, input ready);
  modport sink   (input valid, kind, value, start_position, output ready);
endinterface

[design/ntdc_result_if.sv]
// ---------------------------------------------------------------------------
// ntdc_result_if
// Output channel: one changed display position per transfer.
// ---------------------------------------------------------------------------
interface ntdc_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] position;
  logic [7:0] character;
  logic       last;

  modport source (output valid, position, character, last, input ready);
  modport sink   (input valid, position, character, last, output ready);
endinterface

[design/ntdc_bin2bcd.sv]
// ---------------------------------------------------------------------------
// ntdc_bin2bcd
// Bit-serial binary to BCD (shift and add-3), leading zero strip, then
// hands out digits most significant first, one per take.
// ---------------------------------------------------------------------------
module ntdc_bin2bcd
  import ntdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic [VALUE_W-1:0] mag,
  input  logic               take,
  output cvt_status_t        status
);

  localparam logic [1:0] C_IDLE  = 2'd0;
  localparam logic [1:0] C_SHIFT = 2'd1;
  localparam logic [1:0] C_STRIP = 2'd2;
  localparam logic [1:0] C_READY = 2'd3;

  logic [1:0]             state;
  logic [BCD_W-1:0]       bcd;
  logic [BCD_W-1:0]       adj;
  logic [VALUE_W-1:0]     sh;
  logic [BIT_CNT_W-1:0]   cnt;
  logic [DIGIT_CNT_W-1:0] nd;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (go) begin
            state <= C_SHIFT;
          end
        end
        C_SHIFT: begin
          if (cnt == BIT_CNT_W'(VALUE_W - 1)) begin
            state <= C_STRIP;
          end
        end
        C_STRIP: begin
          if (bcd[BCD_W-1 -: 4] != 4'd0 || nd == DIGIT_CNT_W'(1)) begin
            state <= C_READY;
          end
        end
        C_READY: begin
          if (go) begin
            state <= C_SHIFT;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      sh  <= mag;
      bcd <= '0;
      cnt <= '0;
      nd  <= DIGIT_CNT_W'(DIGITS);
    end else if (state == C_SHIFT) begin
      bcd <= {adj[BCD_W-2:0], sh[VALUE_W-1]};
      sh  <= {sh[VALUE_W-2:0], 1'b0};
      cnt <= cnt + 1'b1;
    end else if (state == C_STRIP) begin
      if (bcd[BCD_W-1 -: 4] == 4'd0 && nd != DIGIT_CNT_W'(1)) begin
        bcd <= {bcd[BCD_W-5:0], 4'd0};
        nd  <= nd - 1'b1;
      end
    end else if (state == C_READY && take && nd != '0) begin
      bcd <= {bcd[BCD_W-5:0], 4'd0};
      nd  <= nd - 1'b1;
    end
  end

  assign status.ready = (state == C_READY);
  assign status.avail = (nd != '0);
  assign status.digit = bcd[BCD_W-1 -: 4];

endmodule

[design/number_to_display_char_diff.sv]
// ---------------------------------------------------------------------------
// number_to_display_char_diff
// Decimal display writer that emits only the positions that changed.
// ---------------------------------------------------------------------------
// Channels: item (kind, value, start_position) in, result (position,
// character, last) out, both valid/ready; a transfer happens when both are
// high at a rising edge. Each item is written as left-aligned decimal text
// (leading '-' for negative signed values) from start_position to the end of
// the display, padded with spaces, and compared with the shadow of the display.
// Each differing position yields one result in ascending order; the final one
// carries last. An item that changes nothing yields no result.
// Timing: one item at a time. A start step, the bit-serial BCD converter,
// its leading zero strip and a handoff, then one display position per cycle
// while the scan is not stalled, from start_position to the end (at most 16),
// plus a flush step. A new item is taken as soon as the previous one is
// flushed, even if its last result still waits in the output register.
// A stalled receiver holds the scan only when a second change is found while
// the output register and the one-entry lookahead slot are both full; the
// flush waits until the output register is free.
// Reset (synchronous) sets every shadow character to a space, empties the
// output and returns to idle.
// ---------------------------------------------------------------------------
module number_to_display_char_diff
  import ntdc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  ntdc_item_if.sink     item,
  ntdc_result_if.source result
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CONV  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]           state;
  logic [POS_CNT_W-1:0] pos;
  logic                 sign_pend;
  logic [7:0]           shadow [DISPLAY_CHARS];

  logic                 hold_v;
  logic [3:0]           hold_pos;
  logic [7:0]           hold_char;

  logic                 out_valid;
  logic [3:0]           out_pos;
  logic [7:0]           out_char;
  logic                 out_last;

  logic                 accept;
  logic                 start_ok;
  logic                 neg;
  logic [VALUE_W-1:0]   mag;
  logic                 cvt_go;
  logic                 cvt_take;
  cvt_status_t          cvt;

  logic [7:0]           ch;
  logic                 diff;
  logic                 out_free;
  logic                 stall;
  logic                 scan_step;
  logic                 flush_do;

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign start_ok   = 32'(item.start_position) < DISPLAY_CHARS;
  assign neg        = item.kind && item.value[VALUE_W-1];
  assign mag        = neg ? (~item.value + 1'b1) : item.value;
  assign cvt_go     = accept && start_ok;

  ntdc_bin2bcd u_bin2bcd (
    .clk    (clk),
    .rst    (rst),
    .go     (cvt_go),
    .mag    (mag),
    .take   (cvt_take),
    .status (cvt)
  );

  always_comb begin
    if (sign_pend) begin
      ch = CHAR_MINUS;
    end else if (cvt.avail) begin
      ch = CHAR_ZERO | {4'd0, cvt.digit};
    end else begin
      ch = CHAR_SPACE;
    end
  end

  assign diff      = shadow[pos[POS_IDX_W-1:0]] != ch;
  assign out_free  = !out_valid || result.ready;
  // a second change needs the lookahead slot to drain into the output
  assign stall     = diff && hold_v && !out_free;
  assign scan_step = (state == S_SCAN) && !stall;
  assign cvt_take  = scan_step && !sign_pend;
  assign flush_do  = (state == S_FLUSH) && hold_v && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cvt_go) begin
            state <= S_CONV;
          end
        end
        S_CONV: begin
          if (cvt.ready) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_step && pos == POS_CNT_W'(DISPLAY_CHARS - 1)) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (!hold_v || out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cvt_go) begin
      pos       <= POS_CNT_W'(item.start_position);
      sign_pend <= neg;
    end else if (scan_step) begin
      pos       <= pos + 1'b1;
      sign_pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DISPLAY_CHARS; i++) begin
        shadow[i] <= CHAR_SPACE;
      end
    end else if (scan_step && diff) begin
      shadow[pos[POS_IDX_W-1:0]] <= ch;
    end
  end

  // one-entry lookahead: a change is released only once it is known
  // whether another follows
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
    end else if (scan_step && diff) begin
      hold_v <= 1'b1;
    end else if (flush_do) begin
      hold_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_step && diff) begin
      hold_pos  <= 4'(pos);
      hold_char <= ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((scan_step && diff && hold_v) || flush_do) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((scan_step && diff && hold_v) || flush_do) begin
      out_pos  <= hold_pos;
      out_char <= hold_char;
      out_last <= flush_do;
    end
  end

  assign result.valid     = out_valid;
  assign result.position  = out_pos;
  assign result.character = out_char;
  assign result.last      = out_last;

  a_hold_in_scan: assert property (@(posedge clk) disable iff (rst)
    hold_v |-> (state == S_SCAN || state == S_FLUSH))
    else $error("lookahead slot full outside scan");

  a_scan_needs_digits: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> cvt.ready)
    else $error("scan running before conversion finished");

  a_flush_marks_last: assert property (@(posedge clk) disable iff (rst)
    flush_do |=> (out_valid && out_last && state == S_IDLE && !hold_v))
    else $error("final change not released with last");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !hold_v)
    else $error("pending change left behind at idle");

endmodule
